FILE: rtl/core/slps_pkg.sv
// shared types, register map and pattern table for the status led pattern sequencer
// no dependencies; imported by status_led_pattern_sequencer

package slps_pkg;

   // input command codes
   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_STATE    = 2'd1,
      CMD_OVERRIDE = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   // led patterns
   typedef enum logic [2:0] {
      PAT_OFF    = 3'd0,
      PAT_ON     = 3'd1,
      PAT_SLOW   = 3'd2,
      PAT_MEDIUM = 3'd3,
      PAT_FAST   = 3'd4
   } pat_type;

   typedef struct packed {
      pat_type state_pat;
      pat_type activity_pat;
   } pat_pair_type;

   localparam int unsigned IntervalWidth = 16;
   localparam int unsigned StateWidth    = 5;
   localparam int unsigned AddrWidth     = 5;

   // register indexes (byte address is four times the index)
   localparam logic [2:0] REG_SLOW     = 3'd0;
   localparam logic [2:0] REG_MEDIUM   = 3'd1;
   localparam logic [2:0] REG_FAST     = 3'd2;
   localparam logic [2:0] REG_IDLE     = 3'd3;
   localparam logic [2:0] REG_OVERRIDE = 3'd4;

   localparam logic [IntervalWidth-1:0] SlowReset     = 16'd1500;
   localparam logic [IntervalWidth-1:0] MediumReset   = 16'd700;
   localparam logic [IntervalWidth-1:0] FastReset     = 16'd150;
   localparam logic [IntervalWidth-1:0] IdleReset     = 16'd250;
   localparam logic [IntervalWidth-1:0] OverrideReset = 16'd50;

   // provisioning keeps the override alive across a state write
   localparam logic [StateWidth-1:0] StateProvisioning = 5'd2;

   // codes above the table blink fast on both leds
   function automatic pat_pair_type pattern_lookup(input logic [StateWidth-1:0] code);
      pat_pair_type p;
      case (code)
         5'd0:    p = '{PAT_SLOW,   PAT_OFF};
         5'd1:    p = '{PAT_SLOW,   PAT_FAST};
         5'd2:    p = '{PAT_MEDIUM, PAT_MEDIUM};
         5'd3:    p = '{PAT_OFF,    PAT_FAST};
         5'd4:    p = '{PAT_SLOW,   PAT_SLOW};
         5'd5:    p = '{PAT_ON,     PAT_SLOW};
         5'd6:    p = '{PAT_SLOW,   PAT_ON};
         5'd7:    p = '{PAT_ON,     PAT_OFF};
         5'd8:    p = '{PAT_ON,     PAT_MEDIUM};
         5'd9:    p = '{PAT_ON,     PAT_FAST};
         5'd10:   p = '{PAT_OFF,    PAT_ON};
         5'd11:   p = '{PAT_ON,     PAT_ON};
         5'd12:   p = '{PAT_ON,     PAT_FAST};
         5'd13:   p = '{PAT_FAST,   PAT_FAST};
         5'd14:   p = '{PAT_FAST,   PAT_OFF};
         5'd15:   p = '{PAT_SLOW,   PAT_SLOW};
         default: p = '{PAT_FAST,   PAT_FAST};
      endcase
      return p;
   endfunction

   function automatic logic pat_blinks(input pat_type p);
      return (p == PAT_SLOW) || (p == PAT_MEDIUM) || (p == PAT_FAST);
   endfunction

   // a zero interval behaves as one tick
   function automatic logic [IntervalWidth-1:0] effective(
      input logic [IntervalWidth-1:0] v
   );
      return (v == '0) ? IntervalWidth'(1) : v;
   endfunction

endpackage

FILE: rtl/core/status_led_pattern_sequencer.sv
// top level of the status led pattern sequencer: input register, update logic, result register
// depends on slps_pkg
//
// usage
//  - req channel carries one command per transfer: a tick, a device state write or an
//    override write, the command kind on req_tuser; rsp channel returns one transfer per
//    command with both led levels, the stored state code and the override flag as they
//    stand after that command
//  - apb-style port holds the five interval registers (ticks, 16 bits each); write them
//    only while no command is in flight
//  - path: a command accepted into the input register is processed by the update logic
//    and loaded into the result register, from which its rsp transfer is offered
//    (one input register, one result register, the update logic between them)
//  - throughput: one command per cycle unless rsp holds off, set by the single pass from the
//    input register through the pattern table, the interval compare and the counter reload
//  - stall: while rsp is held off the result register keeps its transfer and the input
//    register still takes one more command; req_tready drops only when both are full
//  - reset: intervals return to their defaults, state code to boot, override, blink phase,
//    leds and wait counter to zero, so the first tick performs an update

module status_led_pattern_sequencer #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tuser: [1:0] cmd
   input  logic [1:0]  req_tuser,
   // req_tdata: [4:0] state_code, [5] override_enable
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [0] state lamp, [1] activity lamp, [6:2] current_state, [7] override_active
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [slps_pkg::AddrWidth-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import slps_pkg::*;

   // interval registers
   logic [IntervalWidth-1:0] slow_ff, medium_ff, fast_ff, idle_ff, override_int_ff;
   logic [2:0]               reg_index;
   logic                     cfg_write;

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   cmd_type               s1_cmd_ff;
   logic [StateWidth-1:0] s1_code_ff;
   logic                  s1_en_ff;
   logic                  advance;
   logic                  process;

   // block state
   logic [StateWidth-1:0]  device_state_ff, device_state_in;
   logic                   override_flag_ff, override_flag_in;
   logic                   blink_phase_ff, blink_phase_in;
   logic [COUNT_WIDTH-1:0] wait_count_ff, wait_count_in;
   logic                   state_lamp_ff, state_lamp_in;
   logic                   activity_lamp_ff, activity_lamp_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;

   // update datapath
   pat_pair_type             pats;
   logic [IntervalWidth-1:0] state_period, activity_period;
   logic [IntervalWidth-1:0] wait_ticks;
   logic [IntervalWidth-1:0] reload_raw;
   logic [COUNT_WIDTH-1:0]   reload_count;

   // ---------------------------------------------------------------- configuration
   assign pready    = 1'b1;
   assign reg_index = paddr[AddrWidth-1:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_ff         <= SlowReset;
         medium_ff       <= MediumReset;
         fast_ff         <= FastReset;
         idle_ff         <= IdleReset;
         override_int_ff <= OverrideReset;
      end else if (cfg_write) begin
         unique case (reg_index)
            REG_SLOW:     slow_ff         <= pwdata[IntervalWidth-1:0];
            REG_MEDIUM:   medium_ff       <= pwdata[IntervalWidth-1:0];
            REG_FAST:     fast_ff         <= pwdata[IntervalWidth-1:0];
            REG_IDLE:     idle_ff         <= pwdata[IntervalWidth-1:0];
            REG_OVERRIDE: override_int_ff <= pwdata[IntervalWidth-1:0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SLOW:     prdata = 32'(slow_ff);
         REG_MEDIUM:   prdata = 32'(medium_ff);
         REG_FAST:     prdata = 32'(fast_ff);
         REG_IDLE:     prdata = 32'(idle_ff);
         REG_OVERRIDE: prdata = 32'(override_int_ff);
         default:      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow control
   // the whole pass moves when the result register is empty or being emptied
   assign advance     = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || advance;
   assign process     = s1_valid_ff && advance;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_cmd_ff  <= cmd_type'(req_tuser);
         s1_code_ff <= req_tdata[4:0];
         s1_en_ff   <= req_tdata[5];
      end
      if (process) begin
         rsp_data_ff <= {override_flag_in, device_state_in, activity_lamp_in, state_lamp_in};
      end
   end

   // ---------------------------------------------------------------- update datapath
   assign pats = pattern_lookup(device_state_ff);

   always_comb begin
      case (pats.state_pat)
         PAT_SLOW:   state_period = effective(slow_ff);
         PAT_MEDIUM: state_period = effective(medium_ff);
         default:    state_period = effective(fast_ff);
      endcase
      case (pats.activity_pat)
         PAT_SLOW:   activity_period = effective(slow_ff);
         PAT_MEDIUM: activity_period = effective(medium_ff);
         default:    activity_period = effective(fast_ff);
      endcase
   end

   // wait before the next update: state led blink wins over idle, then the shorter
   // activity blink period if any; the override has its own interval
   always_comb begin
      if (override_flag_ff) begin
         wait_ticks = effective(override_int_ff);
      end else begin
         wait_ticks = effective(idle_ff);
         if (pat_blinks(pats.state_pat)) begin
            wait_ticks = state_period;
         end
         if (pat_blinks(pats.activity_pat) && (activity_period < wait_ticks)) begin
            wait_ticks = activity_period;
         end
      end
   end

   // counter loads the wait minus one, saturating when the counter is narrower
   assign reload_raw = wait_ticks - IntervalWidth'(1);

   generate
      if (COUNT_WIDTH >= IntervalWidth) begin : g_wide_count
         assign reload_count = COUNT_WIDTH'(reload_raw);
      end else begin : g_narrow_count
         localparam logic [IntervalWidth-1:0] CountMax =
            IntervalWidth'((64'd1 << COUNT_WIDTH) - 64'd1);
         assign reload_count = (reload_raw > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                                       : reload_raw[COUNT_WIDTH-1:0];
      end
   endgenerate

   always_comb begin
      device_state_in  = device_state_ff;
      override_flag_in = override_flag_ff;
      blink_phase_in   = blink_phase_ff;
      wait_count_in    = wait_count_ff;
      state_lamp_in    = state_lamp_ff;
      activity_lamp_in = activity_lamp_ff;
      if (process) begin
         case (s1_cmd_ff)
            CMD_TICK: begin
               if (wait_count_ff != '0) begin
                  wait_count_in = wait_count_ff - COUNT_WIDTH'(1);
               end else begin
                  wait_count_in = reload_count;
                  if (override_flag_ff) begin
                     state_lamp_in    = 1'b1;
                     activity_lamp_in = 1'b1;
                  end else begin
                     // off and on are fixed levels, any blink shows the shared phase
                     case (pats.state_pat)
                        PAT_OFF: state_lamp_in = 1'b0;
                        PAT_ON:  state_lamp_in = 1'b1;
                        default: state_lamp_in = blink_phase_ff;
                     endcase
                     case (pats.activity_pat)
                        PAT_OFF: activity_lamp_in = 1'b0;
                        PAT_ON:  activity_lamp_in = 1'b1;
                        default: activity_lamp_in = blink_phase_ff;
                     endcase
                     blink_phase_in = !blink_phase_ff;
                  end
               end
            end
            CMD_STATE: begin
               device_state_in = s1_code_ff;
               if (s1_code_ff != StateProvisioning) begin
                  override_flag_in = 1'b0;
               end
            end
            CMD_OVERRIDE: begin
               override_flag_in = s1_en_ff;
               if (s1_en_ff) begin
                  state_lamp_in    = 1'b1;
                  activity_lamp_in = 1'b1;
               end
            end
            CMD_UNUSED: ;  // reports the current state only
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_state_ff  <= '0;
         override_flag_ff <= 1'b0;
         blink_phase_ff   <= 1'b0;
         wait_count_ff    <= '0;
         state_lamp_ff    <= 1'b0;
         activity_lamp_ff <= 1'b0;
      end else begin
         device_state_ff  <= device_state_in;
         override_flag_ff <= override_flag_in;
         blink_phase_ff   <= blink_phase_in;
         wait_count_ff    <= wait_count_in;
         state_lamp_ff    <= state_lamp_in;
         activity_lamp_ff <= activity_lamp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a state write lands in the stored code
   assert property (@(posedge clock) disable iff (reset)
      process && (s1_cmd_ff == CMD_STATE) |=> device_state_ff == $past(s1_code_ff))
      else $error("state write not stored");

   // enabling the override lights both leds at once
   assert property (@(posedge clock) disable iff (reset)
      process && (s1_cmd_ff == CMD_OVERRIDE) && s1_en_ff |=>
         state_lamp_ff && activity_lamp_ff && override_flag_ff)
      else $error("override enable did not light both leds");

   // the wait counter only moves on a processed tick
   assert property (@(posedge clock) disable iff (reset)
      !(process && (s1_cmd_ff == CMD_TICK)) |=> $stable(wait_count_ff))
      else $error("wait counter moved without a tick");

   // an empty result register never holds off the input side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with result register empty");
`endif

endmodule

FILE: tb/tb_status_led_pattern_sequencer.sv
// self-checking testbench for status_led_pattern_sequencer: random and directed commands on req,
// led levels on rsp checked against an in-bench model of the sequencer
// depends on slps_pkg and the status_led_pattern_sequencer rtl

module tb_status_led_pattern_sequencer;
   import slps_pkg::*;

   localparam int unsigned RunLimit = 300000;   // cycles before the run is called hung
   localparam int unsigned SettleCycles = 4;    // pipeline settle margin after draining
   localparam int unsigned HoldCycles = 120;    // long rsp back-pressure stretch

   // one command as {req_tdata[5:0], req_tuser}, lowest field last
   typedef struct packed {
      logic       override_en;
      logic [4:0] code;
      cmd_type    cmd;
   } led_cmd_type;

   // one result as packed on rsp_tdata, lowest field last
   typedef struct packed {
      logic       override_on;
      logic [4:0] stored_state;
      logic       activity_lamp;
      logic       state_lamp;
   } led_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;     // [1:0] cmd
   logic [7:0]  req_tdata = '0;     // [4:0] state_code, [5] override_enable
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [0] state lamp, [1] activity lamp, [6:2] current_state,
                                    // [7] override_active
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [AddrWidth-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   status_led_pattern_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #6 clock = ~clock;

   // commands waiting for the driver, and led results still owed by the block
   led_cmd_type    cmd_backlog [$];
   led_result_type expected_leds [$];
   int unsigned fault_count = 0;
   int unsigned cycle_count = 0;
   bit          calm = 1'b0;        // no idling on either side while set
   bit          hold_armed = 1'b0;  // asks the rsp side for one long hold-off
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;

   // ---------------------------------------------------------------------------------------
   // sequencer model: interval registers and led state as they stand after each transfer
   // ---------------------------------------------------------------------------------------
   logic [IntervalWidth-1:0] interval_reg [5] =
      '{SlowReset, MediumReset, FastReset, IdleReset, OverrideReset};
   logic [StateWidth-1:0]    seq_state = '0;
   logic                     seq_override = 1'b0;
   logic                     seq_phase = 1'b0;
   logic [IntervalWidth-1:0] seq_wait = '0;
   logic                     seq_state_lamp = 1'b0;
   logic                     seq_activity_lamp = 1'b0;

   // per-state patterns of the state led and the activity led
   pat_type state_map [16] = '{
      PAT_SLOW, PAT_SLOW, PAT_MEDIUM, PAT_OFF, PAT_SLOW, PAT_ON, PAT_SLOW, PAT_ON,
      PAT_ON, PAT_ON, PAT_OFF, PAT_ON, PAT_ON, PAT_FAST, PAT_FAST, PAT_SLOW
   };
   pat_type activity_map [16] = '{
      PAT_OFF, PAT_FAST, PAT_MEDIUM, PAT_FAST, PAT_SLOW, PAT_SLOW, PAT_ON, PAT_OFF,
      PAT_MEDIUM, PAT_FAST, PAT_ON, PAT_ON, PAT_FAST, PAT_FAST, PAT_OFF, PAT_SLOW
   };

   // a register holding zero counts as one tick
   function automatic logic [IntervalWidth-1:0] ticks_of(input logic [IntervalWidth-1:0] v);
      return (v == '0) ? IntervalWidth'(1) : v;
   endfunction

   function automatic logic [IntervalWidth-1:0] period_of(input pat_type p);
      case (p)
         PAT_SLOW:   return ticks_of(interval_reg[REG_SLOW]);
         PAT_MEDIUM: return ticks_of(interval_reg[REG_MEDIUM]);
         default:    return ticks_of(interval_reg[REG_FAST]);
      endcase
   endfunction

   function automatic logic is_blinking(input pat_type p);
      return (p != PAT_OFF) && (p != PAT_ON);
   endfunction

   // blinking leds show the shared phase bit as it was before the toggle
   function automatic logic level_of(input pat_type p);
      if (p == PAT_OFF) return 1'b0;
      if (p == PAT_ON) return 1'b1;
      return seq_phase;
   endfunction

   // applies one command to the model and returns the result the block must report
   function automatic led_result_type predict_leds(input led_cmd_type c);
      pat_type                  sp;
      pat_type                  ap;
      logic [IntervalWidth-1:0] span;
      led_result_type           r;
      case (c.cmd)
         CMD_TICK: begin
            if (seq_wait != '0) begin
               seq_wait = seq_wait - 1'b1;
            end else if (seq_override) begin
               // both-on override: phase bit left alone
               seq_state_lamp = 1'b1;
               seq_activity_lamp = 1'b1;
               seq_wait = ticks_of(interval_reg[REG_OVERRIDE]) - 1'b1;
            end else begin
               if (seq_state < 16) begin
                  sp = state_map[seq_state[3:0]];
                  ap = activity_map[seq_state[3:0]];
               end else begin
                  // codes past the table blink fast on both
                  sp = PAT_FAST;
                  ap = PAT_FAST;
               end
               seq_state_lamp = level_of(sp);
               seq_activity_lamp = level_of(ap);
               span = ticks_of(interval_reg[REG_IDLE]);
               if (is_blinking(sp)) span = period_of(sp);
               if (is_blinking(ap) && period_of(ap) < span) span = period_of(ap);
               seq_phase = ~seq_phase;
               seq_wait = span - 1'b1;
            end
         end
         CMD_STATE: begin
            // provisioning keeps the override
            if (c.code != StateProvisioning) seq_override = 1'b0;
            seq_state = c.code;
         end
         CMD_OVERRIDE: begin
            seq_override = c.override_en;
            if (c.override_en) begin
               seq_state_lamp = 1'b1;
               seq_activity_lamp = 1'b1;
            end
         end
         default: ;
      endcase
      r.state_lamp = seq_state_lamp;
      r.activity_lamp = seq_activity_lamp;
      r.stored_state = seq_state;
      r.override_on = seq_override;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // req driver: predicts each accepted transfer, then offers the next command or idles
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      led_cmd_type next_cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser <= '0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready)
            expected_leds.push_back(predict_leds(led_cmd_type'({req_tdata[5:0], req_tuser})));
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
               next_cmd = cmd_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_cmd.cmd;
               req_tdata <= {2'b00, next_cmd.override_en, next_cmd.code};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp ready: random stalls, one long hold-off while the req side keeps offering
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_armed && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HoldCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 35);
      end
   end

   // rsp monitor: every transfer checked field by field against the oldest expectation
   always @(posedge clock) begin
      led_result_type got;
      led_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = led_result_type'(rsp_tdata);
         if (expected_leds.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected rsp transfer, actual %h", $time, rsp_tdata);
         end else begin
            want = expected_leds.pop_front();
            if (got.state_lamp !== want.state_lamp) begin
               fault_count++;
               $display("%0t: state lamp expected %0d actual %0d",
                        $time, want.state_lamp, got.state_lamp);
            end
            if (got.activity_lamp !== want.activity_lamp) begin
               fault_count++;
               $display("%0t: activity lamp expected %0d actual %0d",
                        $time, want.activity_lamp, got.activity_lamp);
            end
            if (got.stored_state !== want.stored_state) begin
               fault_count++;
               $display("%0t: current_state expected %0d actual %0d",
                        $time, want.stored_state, got.stored_state);
            end
            if (got.override_on !== want.override_on) begin
               fault_count++;
               $display("%0t: override_active expected %0d actual %0d",
                        $time, want.override_on, got.override_on);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RunLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic void queue_cmd(input cmd_type op, input logic [4:0] code,
                                     input logic en);
      led_cmd_type c;
      c.cmd = op;
      c.code = code;
      c.override_en = en;
      cmd_backlog.push_back(c);
   endfunction

   // mostly ticks, with state writes leaning towards provisioning now and then
   function automatic void load_random(input int unsigned count);
      int unsigned pick;
      logic [4:0]  code;
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         code = ($urandom_range(3) == 0) ? StateProvisioning : 5'($urandom_range(31));
         if (pick < 65) queue_cmd(CMD_TICK, code, 1'($urandom_range(1)));
         else if (pick < 80) queue_cmd(CMD_STATE, code, 1'($urandom_range(1)));
         else if (pick < 93) queue_cmd(CMD_OVERRIDE, code, 1'($urandom_range(1)));
         else queue_cmd(CMD_UNUSED, code, 1'($urandom_range(1)));
      end
   endfunction

   // apb write: setup cycle, then access cycle until pready
   task automatic write_interval(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      // indexes past the last register are dropped
      if (idx <= REG_OVERRIDE) interval_reg[idx] = value[IntervalWidth-1:0];
   endtask

   // every register gets a value in [lo, hi]; upper data bits are junk the block must drop
   task automatic set_intervals(input int unsigned lo, input int unsigned hi);
      for (int i = REG_SLOW; i <= REG_OVERRIDE; i++)
         write_interval(3'(i), {16'($urandom), 16'($urandom_range(hi, lo))});
      write_interval(3'(REG_OVERRIDE + 1 + $urandom_range(2)), $urandom);
   endtask

   // nothing queued, nothing on req, nothing owed on rsp, then let the pipeline settle
   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_tvalid || expected_leds.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset-value registers: unused command, state writes, override set and clear,
      // provisioning keeping the override, first tick landing under the override
      queue_cmd(CMD_UNUSED, 5'd31, 1'b1);
      queue_cmd(CMD_OVERRIDE, 5'd0, 1'b1);
      queue_cmd(CMD_STATE, StateProvisioning, 1'b0);
      queue_cmd(CMD_STATE, 5'd31, 1'b1);
      queue_cmd(CMD_OVERRIDE, 5'd31, 1'b1);
      queue_cmd(CMD_OVERRIDE, 5'd0, 1'b0);
      queue_cmd(CMD_STATE, 5'd0, 1'b0);
      queue_cmd(CMD_OVERRIDE, 5'd17, 1'b1);
      queue_cmd(CMD_TICK, 5'd0, 1'b0);
      wait_drained();

      // shortest intervals: the wait left by the previous test runs out, then every tick updates
      set_intervals(1, 1);
      load_random(300);
      wait_drained();

      // zero registers act as one tick; walk a few patterns tick by tick
      set_intervals(0, 0);
      queue_cmd(CMD_OVERRIDE, 5'd0, 1'b0);
      queue_cmd(CMD_STATE, 5'd0, 1'b0);
      queue_cmd(CMD_TICK, 5'd0, 1'b0);
      queue_cmd(CMD_TICK, 5'd31, 1'b1);
      queue_cmd(CMD_STATE, 5'd3, 1'b0);
      queue_cmd(CMD_TICK, 5'd0, 1'b0);
      queue_cmd(CMD_STATE, 5'd10, 1'b0);
      queue_cmd(CMD_TICK, 5'd0, 1'b0);
      queue_cmd(CMD_OVERRIDE, 5'd0, 1'b1);
      queue_cmd(CMD_TICK, 5'd0, 1'b0);
      queue_cmd(CMD_STATE, StateProvisioning, 1'b0);
      queue_cmd(CMD_TICK, 5'd0, 1'b0);
      queue_cmd(CMD_STATE, 5'd20, 1'b0);
      queue_cmd(CMD_TICK, 5'd0, 1'b0);
      queue_cmd(CMD_TICK, 5'd0, 1'b0);
      queue_cmd(CMD_STATE, 5'd15, 1'b1);
      load_random(300);
      // rsp stalls long enough for the block to fill and drop req_tready
      hold_armed = 1'b1;
      wait_drained();

      // largest intervals: the counter only counts down after its first reload
      set_intervals(65535, 65535);
      load_random(100);
      wait_drained();

      set_intervals(1, 12);
      load_random(350);
      wait_drained();

      // stretch with no idling on either side
      calm = 1'b1;
      set_intervals(1, 5);
      load_random(350);
      wait_drained();
      calm = 1'b0;

      set_intervals(1, 40);
      load_random(450);
      wait_drained();

      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
